>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the glyph renderer.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pfgr_pkg.sv
// Shared constants, types and font ROM for the page framebuffer glyph renderer.
// Depends on nothing; used by the controller, datapath and top level.
package pfgr_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
	localparam int ADDR_W       = $clog2(STORE_BYTES);
	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_STEPS  = 2 * GLYPH_COLS;
	localparam int IN_TDATA_W   = 40;

	localparam logic [3:0] SPACE_SLOT = 4'd11;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_GLYPH = 2'd1,
		KIND_FILL  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_PIXEL = 3'd1,
		OP_GLYPH = 3'd2,
		OP_FILL  = 3'd3,
		OP_CLEAR = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_item;
		logic cnt_clr;
		logic cnt_inc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic glyph_last;
		logic store_last;
		logic out_busy;
	} sts_t;

	// 5x7 font, one byte per column, bit j is glyph row j
	localparam logic [7:0] GLYPH_ROM [0:15][0:4] = '{
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
		'{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
		'{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
		'{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7F, 8'h40, 8'h40, 8'h40, 8'h00},
		'{8'h3E, 8'h40, 8'h40, 8'h3E, 8'h00},
		'{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
		'{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}
	};

	// Map a character code to its font slot; unknown codes draw a space
	function automatic logic [3:0] glyph_slot(input logic [7:0] code);
		logic [3:0] slot;
		slot = SPACE_SLOT;
		if (code >= 8'h30 && code <= 8'h39) begin
			slot = 4'(code - 8'h30);
		end else begin
			unique case (code)
				8'h3A: slot = 4'd10;
				8'h20: slot = 4'd11;
				8'h4C: slot = 4'd12;
				8'h75: slot = 4'd13;
				8'h78: slot = 4'd14;
				8'h2E: slot = 4'd15;
				default: slot = SPACE_SLOT;
			endcase
		end
		return slot;
	endfunction

endpackage

>>> src/pfgr_ctrl.sv
// Controller state machine of the glyph renderer: sequences each item.
// Depends on pfgr_pkg; drives the datapath through cmd_t, watches sts_t.
module pfgr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_kind,
	output logic               in_ready,
	input  pfgr_pkg::sts_t     sts,
	output pfgr_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PIXEL = 7'b0000100,
		ST_GLYPH = 7'b0001000,
		ST_FILL  = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_LOAD  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd.op        = pfgr_pkg::OP_NONE;
		cmd.load_item = 1'b0;
		cmd.cnt_clr   = 1'b0;
		cmd.cnt_inc   = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op      = pfgr_pkg::OP_CLEAR;
				cmd.cnt_inc = 1'b1;
				if (sts.store_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.cnt_clr   = 1'b1;
					unique case (pfgr_pkg::kind_t'(in_kind))
						pfgr_pkg::KIND_PIXEL: state_d = ST_PIXEL;
						pfgr_pkg::KIND_GLYPH: state_d = ST_GLYPH;
						pfgr_pkg::KIND_FILL:  state_d = ST_FILL;
						pfgr_pkg::KIND_READ:  state_d = ST_READ;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_PIXEL: begin
				cmd.op  = pfgr_pkg::OP_PIXEL;
				state_d = ST_IDLE;
			end
			ST_GLYPH: begin
				cmd.op      = pfgr_pkg::OP_GLYPH;
				cmd.cnt_inc = 1'b1;
				if (sts.glyph_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.op      = pfgr_pkg::OP_FILL;
				cmd.cnt_inc = 1'b1;
				if (sts.store_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				// wait for the output register to drain before reading
				if (!sts.out_busy) begin
					cmd.op  = pfgr_pkg::OP_READ;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state; start with a clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/pfgr_dp.sv
// Datapath of the glyph renderer: item register, step counter, frame memory,
// read-modify-write stage and result register. Depends on pfgr_pkg.
module pfgr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pfgr_pkg::IN_TDATA_W-1:0]    in_data,
	input  pfgr_pkg::cmd_t                     cmd,
	output pfgr_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         out_data
);

	localparam int AW = pfgr_pkg::ADDR_W;

	// latched item fields
	logic [7:0] pos_x_q;
	logic [7:0] pos_y_q;
	logic       ink_q;
	logic [7:0] char_code_q;
	logic [9:0] read_addr_q;

	logic [AW-1:0] cnt_q;

	logic [7:0] mem [pfgr_pkg::STORE_BYTES];
	logic [7:0] rd_s1;
	logic       we_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0] mask_s1;
	logic [7:0] val_s1;

	logic       out_valid_q;
	logic [7:0] out_data_q;

	// step decode
	logic [2:0]  gcol;
	logic        half;
	logic [8:0]  col;
	logic [5:0]  page;
	logic [2:0]  off;
	logic [3:0]  slot;
	logic [6:0]  gbits;
	logic [15:0] m16;
	logic [15:0] d16;
	logic [7:0]  rowok;
	logic [14:0] lin;
	logic [15:0] ra16;
	logic        ra_ok;

	logic          step_we;
	logic [AW-1:0] step_addr;
	logic [7:0]    step_mask;
	logic [7:0]    step_val;
	logic [AW-1:0] rd_addr;

	// Capture the item on acceptance
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pos_x_q     <= in_data[7:0];
			pos_y_q     <= in_data[15:8];
			ink_q       <= in_data[16];
			char_code_q <= in_data[24:17];
			read_addr_q <= in_data[34:25];
		end
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign sts.glyph_last = (cnt_q == AW'(pfgr_pkg::GLYPH_STEPS - 1));
	assign sts.store_last = (cnt_q == AW'(pfgr_pkg::STORE_BYTES - 1));
	assign sts.out_busy   = out_valid_q;

	// Glyph steps run column by column, upper then lower page byte
	assign gcol  = (cmd.op == pfgr_pkg::OP_GLYPH) ? cnt_q[3:1] : 3'd0;
	assign half  = (cmd.op == pfgr_pkg::OP_GLYPH) ? cnt_q[0] : 1'b0;
	assign col   = {1'b0, pos_x_q} + {6'd0, gcol};
	assign page  = {1'b0, pos_y_q[7:3]} + {5'd0, half};
	assign off   = pos_y_q[2:0];
	assign slot  = pfgr_pkg::glyph_slot(char_code_q);
	assign gbits = ink_q ? pfgr_pkg::GLYPH_ROM[slot][gcol][6:0]
	                     : ~pfgr_pkg::GLYPH_ROM[slot][gcol][6:0];
	assign d16   = {9'd0, gbits} << off;
	assign lin   = 15'(page) * 15'(pfgr_pkg::PANEL_WIDTH) + 15'(col);

	// Clip rows below the panel bit by bit
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			rowok[k] = ({page, 3'(k)} < 9'(pfgr_pkg::PANEL_HEIGHT));
		end
	end

	always_comb begin
		m16 = 16'h0000;
		unique case (cmd.op)
			pfgr_pkg::OP_PIXEL: m16 = 16'h0001 << off;
			pfgr_pkg::OP_GLYPH: m16 = 16'h007F << off;
			default:            m16 = 16'h0000;
		endcase
	end

	// Build the write step for the current command
	always_comb begin
		step_we   = 1'b0;
		step_addr = lin[AW-1:0];
		step_mask = 8'h00;
		step_val  = 8'h00;
		unique case (cmd.op)
			pfgr_pkg::OP_PIXEL, pfgr_pkg::OP_GLYPH: begin
				step_mask = (half ? m16[15:8] : m16[7:0]) & rowok;
				step_val  = (cmd.op == pfgr_pkg::OP_PIXEL) ? {8{ink_q}}
				          : (half ? d16[15:8] : d16[7:0]);
				step_we   = (col < 9'(pfgr_pkg::PANEL_WIDTH)) && (step_mask != 8'h00);
			end
			pfgr_pkg::OP_FILL: begin
				step_we   = 1'b1;
				step_addr = cnt_q;
				step_mask = 8'hFF;
				step_val  = {8{ink_q}};
			end
			pfgr_pkg::OP_CLEAR: begin
				step_we   = 1'b1;
				step_addr = cnt_q;
				step_mask = 8'hFF;
				step_val  = 8'h00;
			end
			default: begin
				step_we = 1'b0;
			end
		endcase
	end

	assign ra16    = 16'(read_addr_q);
	assign ra_ok   = (ra16 < 16'(pfgr_pkg::STORE_BYTES));
	assign rd_addr = (cmd.op == pfgr_pkg::OP_READ) ? ra16[AW-1:0] : step_addr;

	// Read port: registered read data
	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
	end

	// Carry the step alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= step_we;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= step_addr;
		mask_s1  <= step_mask;
		val_s1   <= step_val;
	end

	// Write port: merge the masked bits into the byte just read
	always_ff @(posedge clk) begin
		if (we_s1) begin
			mem[waddr_s1] <= (rd_s1 & ~mask_s1) | (val_s1 & mask_s1);
		end
	end

	// Result register: load on read completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= ra_ok ? rd_s1 : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> src/page_framebuffer_glyph_renderer_unit.sv
// Usage: 128x64 monochrome page framebuffer with a 5x7 glyph renderer.
// Input stream: s_axis_tuser carries the item kind (pixel, glyph, fill, read),
// s_axis_tdata the coordinates, ink, character code and read address.
// Output stream: one byte on m_axis_tdata for each read item, in order.
// Per item, from acceptance to the next possible acceptance: a pixel makes its
// read-modify-write step, a glyph ten read-modify-write steps (one per cycle
// through the single read and single write port of the frame memory), a fill
// all 1024 bytes (one byte per cycle), and a read waits for the output register
// to empty, then does its memory read and loads the result. A read result passes
// through the registered memory read and the result register to m_axis_tvalid.
// After arst_n releases, a clearing pass zeroes all 1024 bytes; s_axis_tready
// stays low until it ends.
// The result register decouples the output: pixel, glyph and fill items are
// taken while a result waits; a read item waits until the previous result
// has been taken. Draws off the panel are clipped, never wrapped.
// Depends on pfgr_pkg, pfgr_ctrl, pfgr_dp and assert_macros.svh.
`include "assert_macros.svh"
module page_framebuffer_glyph_renderer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] pos_x, [15:8] pos_y, [16] ink, [24:17] char_code, [34:25] read_addr, zeros
	input  logic [39:0] s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] read_data
	output logic [7:0]  m_axis_tdata
);

	pfgr_pkg::cmd_t cmd;
	pfgr_pkg::sts_t sts;

	// Sequence items
	pfgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame memory and drawing logic
	pfgr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// A result is never loaded over one still waiting
	`ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !sts.out_busy)
	// No memory work is issued while waiting for an item
	`ASSERT_IMP(a_idle_quiet, clk, arst_n, s_axis_tready, cmd.op == pfgr_pkg::OP_NONE)
	// A memory read is always followed by loading the result
	`ASSERT_NEXT(a_read_loads, clk, arst_n, cmd.op == pfgr_pkg::OP_READ, cmd.out_load)

endmodule
